@@ sv/pali_pkg.sv @@
`timescale 1ns / 1ps

package pali_pkg;

    // Result location codes
    localparam logic [1:0] WHERE_INTERIOR = 2'd0;
    localparam logic [1:0] WHERE_START    = 2'd1;
    localparam logic [1:0] WHERE_END      = 2'd2;

    // One quotient bit per divider cell
    localparam int DIV_CELLS = 32;

    typedef struct packed {
        logic [31:0] len;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] heading;
    } t_point;

    // Word handed from one divider cell to the next
    typedef struct packed {
        logic        valid;
        logic [32:0] rem;
        logic [31:0] divisor;
        logic [31:0] quot;
    } t_div_word;

endpackage

@@ sv/pali_div_cell.sv @@
`timescale 1ns / 1ps

module pali_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pali_pkg::t_div_word i_word,
    output pali_pkg::t_div_word o_word
);

    logic               ge;
    logic [32:0]        rem_sub;
    pali_pkg::t_div_word r_word;
    pali_pkg::t_div_word n_word;

    // Compare, subtract on fit, then shift the remainder up one place
    always_comb begin
        ge      = i_word.rem >= {1'b0, i_word.divisor};
        rem_sub = ge ? (i_word.rem - {1'b0, i_word.divisor}) : i_word.rem;
        n_word.valid   = i_word.valid;
        n_word.divisor = i_word.divisor;
        n_word.rem     = {rem_sub[31:0], 1'b0};
        n_word.quot    = {i_word.quot[30:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= n_word.valid;
        end
        r_word.rem     <= n_word.rem;
        r_word.divisor <= n_word.divisor;
        r_word.quot    <= n_word.quot;
    end

    assign o_word = r_word;

endmodule

@@ sv/pali_divider.sv @@
`timescale 1ns / 1ps

module pali_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_valid,
    output logic [31:0] o_quot
);

    pali_pkg::t_div_word chain [pali_pkg::DIV_CELLS + 1];

    // Seed the row; the numerator never exceeds the denominator
    always_comb begin
        chain[0].valid   = i_valid;
        chain[0].rem     = {1'b0, i_num};
        chain[0].divisor = i_den;
        chain[0].quot    = '0;
    end

    for (genvar g = 0; g < pali_pkg::DIV_CELLS; g++) begin : g_cell
        pali_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_word (chain[g]),
            .o_word (chain[g + 1])
        );
    end

    assign o_valid = chain[pali_pkg::DIV_CELLS].valid;
    assign o_quot  = chain[pali_pkg::DIV_CELLS].quot;

endmodule

@@ sv/polyline_arc_length_interpolator_top.sv @@
`timescale 1ns / 1ps

// Polyline arc-length interpolator. A load word (action 0) writes one point
// of the table. A query word (action 1) first checks the start and end clamps;
// otherwise it scans up to point_count - 1 segments, reading one table entry
// a cycle, then a row of 32 divider cells forms the ratio and one shared
// multiplier blends x, y and heading. busy is high while a query is in work.
// The result appears on the o_ ports for exactly one cycle with o_valid; the
// receiver cannot stall it, so it must take every word as it comes.
module polyline_arc_length_interpolator_top #(
    parameter int MAX_POINTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_action,
    input  logic [7:0]  i_point_index,
    input  logic [31:0] i_point_len,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_heading,
    input  logic [31:0] i_query_len,
    output logic        o_valid,
    output logic [31:0] o_out_x,
    output logic [31:0] o_out_y,
    output logic [31:0] o_out_heading,
    output logic [31:0] o_out_len,
    output logic [1:0]  o_where_found
);

    localparam int AW = $clog2(MAX_POINTS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DIFF  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_MUL   = 3'd6;
    localparam logic [2:0] S_ACC   = 3'd7;

    logic [127:0] mem [MAX_POINTS];

    logic [2:0]       r_state, n_state;
    logic [8:0]       r_count;
    logic [31:0]      r_s, n_s;
    pali_pkg::t_point r_rdata;
    pali_pkg::t_point r_first, n_first;
    pali_pkg::t_point r_last, n_last;
    pali_pkg::t_point r_prev, n_prev;
    pali_pkg::t_point r_p0, n_p0;
    pali_pkg::t_point r_p1, n_p1;
    logic [AW:0]      r_idx, n_idx;
    logic [31:0]      r_d, n_d;
    logic [31:0]      r_span, n_span;
    logic [31:0]      r_ratio, n_ratio;
    logic [1:0]       r_k, n_k;
    logic [63:0]      r_prod, n_prod;
    logic [31:0]      r_mag [3];
    logic [31:0]      n_mag [3];
    logic             r_neg [3];
    logic             n_neg [3];
    logic [31:0]      r_res [3];
    logic [31:0]      n_res [3];

    logic             r_valid, n_valid;
    logic [31:0]      r_ox, n_ox, r_oy, n_oy, r_oh, n_oh, r_olen, n_olen;
    logic [1:0]       r_where, n_where;

    logic             accept;
    logic             wr_en;
    logic [AW-1:0]    rd_addr;
    logic [AW:0]      n_pts;
    logic [AW:0]      last_idx;
    logic             div_start;
    logic             div_valid;
    logic [31:0]      div_quot;
    logic [31:0]      base_f [3];
    logic [31:0]      top_f  [3];
    logic [32:0]      diff;
    logic [63:0]      rnd_sum;
    logic [33:0]      base34;
    logic [33:0]      t34;
    logic [33:0]      acc34;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && !i_action && (32'(i_point_index) < 32'(MAX_POINTS));

    // Clamp the point count into 1..MAX_POINTS
    always_comb begin
        if (r_count == 9'd0) begin
            n_pts = (AW + 1)'(1);
        end else if (32'(r_count) > 32'(MAX_POINTS)) begin
            n_pts = (AW + 1)'(MAX_POINTS);
        end else begin
            n_pts = (AW + 1)'(r_count);
        end
        last_idx = n_pts - (AW + 1)'(1);
    end

    // Table store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(i_point_index)] <= {i_point_len, i_point_x, i_point_y, i_point_heading};
        end
        r_rdata <= mem[rd_addr];
    end

    // Pick the table read address for the next cycle
    always_comb begin
        case (r_state)
            S_IDLE:  rd_addr = '0;
            S_FIRST: rd_addr = AW'(last_idx);
            S_LAST:  rd_addr = AW'(1);
            S_SCAN:  rd_addr = AW'(r_idx + (AW + 1)'(1));
            default: rd_addr = '0;
        endcase
    end

    assign div_start = (r_state == S_DIFF);

    pali_divider u_divider (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(div_start),
        .i_num  (r_d),
        .i_den  (r_span),
        .o_valid(div_valid),
        .o_quot (div_quot)
    );

    assign base_f[0] = r_p0.x;
    assign base_f[1] = r_p0.y;
    assign base_f[2] = r_p0.heading;
    assign top_f[0]  = r_p1.x;
    assign top_f[1]  = r_p1.y;
    assign top_f[2]  = r_p1.heading;

    // Sequence one query: clamp checks, scan, divide, blend
    always_comb begin
        n_state = r_state;
        n_s     = r_s;
        n_first = r_first;
        n_last  = r_last;
        n_prev  = r_prev;
        n_p0    = r_p0;
        n_p1    = r_p1;
        n_idx   = r_idx;
        n_d     = r_d;
        n_span  = r_span;
        n_ratio = r_ratio;
        n_k     = r_k;
        n_prod  = r_prod;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_res   = r_res;
        n_valid = 1'b0;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_oh    = r_oh;
        n_olen  = r_olen;
        n_where = r_where;
        diff    = '0;
        rnd_sum = r_prod + 64'h0000_0000_4000_0000;
        base34  = {{2{base_f[r_k][31]}}, base_f[r_k]};
        t34     = {1'b0, rnd_sum[63:31]};
        acc34   = r_neg[r_k] ? (base34 - t34) : (base34 + t34);

        case (r_state)
            S_IDLE: begin
                if (accept && i_action) begin
                    n_s     = i_query_len;
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                n_first = r_rdata;
                n_state = S_LAST;
            end
            S_LAST: begin
                n_last = r_rdata;
                if (r_s <= r_first.len) begin
                    n_valid = 1'b1;
                    n_ox    = r_first.x;
                    n_oy    = r_first.y;
                    n_oh    = r_first.heading;
                    n_olen  = r_first.len;
                    n_where = pali_pkg::WHERE_START;
                    n_state = S_IDLE;
                end else if (r_s >= r_rdata.len) begin
                    n_valid = 1'b1;
                    n_ox    = r_rdata.x;
                    n_oy    = r_rdata.y;
                    n_oh    = r_rdata.heading;
                    n_olen  = r_rdata.len;
                    n_where = pali_pkg::WHERE_END;
                    n_state = S_IDLE;
                end else begin
                    n_prev  = r_first;
                    n_idx   = (AW + 1)'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_s >= r_prev.len && r_s <= r_rdata.len) begin
                    n_p0    = r_prev;
                    n_p1    = r_rdata;
                    n_d     = r_s - r_prev.len;
                    n_span  = r_rdata.len - r_prev.len;
                    n_state = S_DIFF;
                end else if (r_idx >= last_idx) begin
                    n_valid = 1'b1;
                    n_ox    = r_last.x;
                    n_oy    = r_last.y;
                    n_oh    = r_last.heading;
                    n_olen  = r_last.len;
                    n_where = pali_pkg::WHERE_END;
                    n_state = S_IDLE;
                end else begin
                    n_prev = r_rdata;
                    n_idx  = r_idx + (AW + 1)'(1);
                end
            end
            S_DIFF: begin
                for (int f = 0; f < 3; f++) begin
                    diff     = {top_f[f][31], top_f[f]} - {base_f[f][31], base_f[f]};
                    n_neg[f] = diff[32];
                    n_mag[f] = diff[32] ? 32'(-diff) : diff[31:0];
                end
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_valid) begin
                    n_ratio = (r_span == 32'd0) ? 32'd0 : div_quot;
                    n_k     = 2'd0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = 64'(r_mag[r_k]) * 64'(r_ratio);
                n_state = S_ACC;
            end
            S_ACC: begin
                n_res[r_k] = acc34[31:0];
                if (r_k == 2'd2) begin
                    n_valid = 1'b1;
                    n_ox    = r_res[0];
                    n_oy    = r_res[1];
                    n_oh    = acc34[31:0];
                    n_olen  = r_s;
                    n_where = pali_pkg::WHERE_INTERIOR;
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control under reset, payload free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= 9'd2;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
        r_s     <= n_s;
        r_first <= n_first;
        r_last  <= n_last;
        r_prev  <= n_prev;
        r_p0    <= n_p0;
        r_p1    <= n_p1;
        r_idx   <= n_idx;
        r_d     <= n_d;
        r_span  <= n_span;
        r_ratio <= n_ratio;
        r_k     <= n_k;
        r_prod  <= n_prod;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_res   <= n_res;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_oh    <= n_oh;
        r_olen  <= n_olen;
        r_where <= n_where;
    end

    assign o_valid       = r_valid;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_out_heading = r_oh;
    assign o_out_len     = r_olen;
    assign o_where_found = r_where;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int  TABLE_DEPTH = 256;
    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam bit  ACT_LOAD    = 1'b0;
    localparam bit  ACT_QUERY   = 1'b1;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] heading;
        logic [31:0] len;
        logic [1:0]  where_found;
    } t_answer;

    // Polyline table mirror: predicts each query answer and checks the output words
    class arc_table_model;
        pali_pkg::t_point pts[TABLE_DEPTH];
        logic [8:0]       count_reg;
        t_answer          answers[$];
        int               errors;

        function new();
            count_reg = 9'd2;
            errors    = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) pts[i] = '0;
        endfunction

        function int used_points();
            if (count_reg == 0) return 1;
            if (count_reg > TABLE_DEPTH) return TABLE_DEPTH;
            return count_reg;
        endfunction

        // Queue one expected answer at the tail
        function void add_answer(t_answer a);
            answers.insert(answers.size(), a);
        endfunction

        // Move from a toward b by ratio (Q1.31), rounding to nearest, ties away from zero
        function logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [63:0] ratio);
            longint      sa;
            longint      sb;
            longint      diff;
            logic [63:0] mag;
            logic [63:0] step;
            sa   = longint'($signed(a));
            sb   = longint'($signed(b));
            diff = sb - sa;
            mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
            step = (mag * ratio + 64'(1) * (64'd1 << 30)) >> 31;
            if (diff < 0) return 32'(sa - longint'(step));
            return 32'(sa + longint'(step));
        endfunction

        function t_answer from_point(pali_pkg::t_point p, logic [1:0] w);
            t_answer a;
            a.x = p.x; a.y = p.y; a.heading = p.heading; a.len = p.len; a.where_found = w;
            return a;
        endfunction

        function void note_word(bit act, logic [7:0] idx, logic [31:0] l, logic [31:0] x,
                                logic [31:0] y, logic [31:0] h, logic [31:0] q);
            int               n;
            pali_pkg::t_point p0;
            pali_pkg::t_point p1;
            logic [63:0]      d;
            logic [63:0]      span;
            logic [63:0]      ratio;
            t_answer          a;
            if (act == ACT_LOAD) begin
                pts[idx] = '{len: l, x: x, y: y, heading: h};
                return;
            end
            n = used_points();
            if (q <= pts[0].len) begin
                add_answer(from_point(pts[0], pali_pkg::WHERE_START));
                return;
            end
            if (q >= pts[n-1].len) begin
                add_answer(from_point(pts[n-1], pali_pkg::WHERE_END));
                return;
            end
            // First segment that brackets the query wins
            for (int i = 0; i + 1 < n; i++) begin
                p0 = pts[i];
                p1 = pts[i+1];
                if (q >= p0.len && q <= p1.len) begin
                    d     = 64'(q - p0.len);
                    span  = 64'(p1.len - p0.len);
                    ratio = (span != 0) ? (d << 31) / span : 64'd0;
                    a.x = blend(p0.x, p1.x, ratio);
                    a.y = blend(p0.y, p1.y, ratio);
                    a.heading = blend(p0.heading, p1.heading, ratio);
                    a.len = q;
                    a.where_found = pali_pkg::WHERE_INTERIOR;
                    add_answer(a);
                    return;
                end
            end
            add_answer(from_point(pts[n-1], pali_pkg::WHERE_END));
        endfunction

        function void check_answer(t_answer got);
            t_answer want;
            if (answers.size() == 0) begin
                $display("%0t: unexpected word x=%h y=%h h=%h len=%h where=%0d", $time,
                         got.x, got.y, got.heading, got.len, got.where_found);
                errors++;
                return;
            end
            want = answers.pop_front();
            if (got.x != want.x) begin
                $display("%0t: x expected %h actual %h", $time, want.x, got.x); errors++;
            end
            if (got.y != want.y) begin
                $display("%0t: y expected %h actual %h", $time, want.y, got.y); errors++;
            end
            if (got.heading != want.heading) begin
                $display("%0t: heading expected %h actual %h", $time, want.heading,
                         got.heading);
                errors++;
            end
            if (got.len != want.len) begin
                $display("%0t: len expected %h actual %h", $time, want.len, got.len); errors++;
            end
            if (got.where_found != want.where_found) begin
                $display("%0t: where expected %0d actual %0d", $time, want.where_found,
                         got.where_found);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [8:0]  i_cfg_wdata;
    logic        i_action;
    logic [7:0]  i_point_index;
    logic [31:0] i_point_len;
    logic [31:0] i_point_x;
    logic [31:0] i_point_y;
    logic [31:0] i_point_heading;
    logic [31:0] i_query_len;
    logic        o_valid;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic [31:0] o_out_heading;
    logic [31:0] o_out_len;
    logic [1:0]  o_where_found;

    arc_table_model table_model;
    int             gap_pct;
    int unsigned    cycles = 0;

    polyline_arc_length_interpolator_top dut (
        .i_clk, .i_rst_n, .start, .busy, .i_cfg_we, .i_cfg_wdata,
        .i_action, .i_point_index, .i_point_len, .i_point_x, .i_point_y,
        .i_point_heading, .i_query_len, .o_valid, .o_out_x, .o_out_y,
        .o_out_heading, .o_out_len, .o_where_found
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Take every result word as it comes
    always @(posedge i_clk) begin
        t_answer got;
        if (i_rst_n && o_valid) begin
            got.x = o_out_x; got.y = o_out_y; got.heading = o_out_heading;
            got.len = o_out_len; got.where_found = o_where_found;
            table_model.check_answer(got);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_word(bit act, logic [7:0] idx, logic [31:0] l, logic [31:0] x,
                             logic [31:0] y, logic [31:0] h, logic [31:0] q);
        @(negedge i_clk);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_action = act; i_point_index = idx; i_point_len = l; i_point_x = x;
        i_point_y = y; i_point_heading = h; i_query_len = q;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        table_model.note_word(act, idx, l, x, y, h, q);
    endtask

    task automatic load_point(int idx, logic [31:0] l, logic [31:0] x, logic [31:0] y,
                              logic [31:0] h);
        send_word(ACT_LOAD, idx[7:0], l, x, y, h, $urandom);
    endtask

    task automatic query(logic [31:0] q);
        send_word(ACT_QUERY, 8'($urandom), $urandom, $urandom, $urandom, $urandom, q);
    endtask

    // Drop start, wait for all answers, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (table_model.answers.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(logic [8:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        table_model.count_reg = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        i_cfg_wdata = 9'($urandom);
    endtask

    // Fill slots in use: mostly ascending lengths, sometimes scrambled
    task automatic fill_table(int n, bit scrambled);
        logic [31:0] l;
        logic [31:0] step_max;
        l = $urandom_range(0, 2000);
        step_max = 32'hFFFF_0000 / n;
        for (int i = 0; i < n; i++) begin
            load_point(i, scrambled ? $urandom : l, $urandom, $urandom, $urandom);
            l = l + (($urandom_range(9) == 0) ? 32'd0 : ($urandom % step_max));
        end
    endtask

    function automatic logic [31:0] pick_query(int n);
        int          i;
        logic [31:0] a;
        logic [31:0] b;
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3: return table_model.pts[$urandom_range(n - 1)].len;
            default: begin
                i = (n > 1) ? $urandom_range(n - 2) : 0;
                a = table_model.pts[i].len;
                b = table_model.pts[(n > 1) ? i + 1 : 0].len;
                if (b > a) return a + 32'($urandom % (33'(b) - 33'(a) + 33'd1));
                return $urandom;
            end
        endcase
    endfunction

    initial begin
        int          n;
        int          phase;
        int          filled;
        logic [8:0]  counts[$];
        table_model = new();
        gap_pct = 0;
        filled = 0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_action = ACT_LOAD;
        i_point_index = '0;
        i_point_len = '0;
        i_point_x = '0;
        i_point_y = '0;
        i_point_heading = '0;
        i_query_len = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: two points at the field extremes, reset count
        load_point(0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        load_point(1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        query(32'd0);
        query(32'hFFFF_FFFF);
        query(32'h8000_0000);
        query(32'd1);
        query(32'hFFFF_FFFE);
        load_point(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Start length not below end length: start test wins
        load_point(0, 32'd500, 32'd1, 32'd2, 32'd3);
        load_point(1, 32'd100, 32'd4, 32'd5, 32'd6);
        query(32'd300);
        query(32'd600);
        // Ascending then descending lengths, queried under counts 3 and 0
        load_point(0, 32'd100, 32'd10, 32'd20, 32'd30);
        load_point(1, 32'd1000, 32'd11, 32'd21, 32'd31);
        load_point(2, 32'd50, 32'd12, 32'd22, 32'd32);
        load_point(3, 32'd2000, 32'd13, 32'd23, 32'd33);
        drain();
        write_count(9'd3);
        query(32'd1500);
        query(32'd700);
        drain();
        write_count(9'd0);
        query(32'd5);
        query(32'd200);
        drain();

        // Random phases over several counts, extremes included; grow the table
        // only when a count needs more slots than are loaded
        counts = {9'd1, 9'd2, 9'd4, 9'd16, 9'd0, 9'd256, 9'd511, 9'd300, 9'd170,
                  9'd85, 9'd8, 9'd32};
        phase = 0;
        foreach (counts[k]) begin
            case (phase % 4)
                0: gap_pct = 0;
                1: gap_pct = 68;
                2: gap_pct = 0;
                default: gap_pct = 12;
            endcase
            phase++;
            write_count(counts[k]);
            n = table_model.used_points();
            if (n > filled) begin
                fill_table(n, $urandom_range(4) == 0);
                filled = n;
            end
            for (int j = 0; j < 10; j++) begin
                if ($urandom_range(4) == 0)
                    load_point($urandom_range(255), $urandom, $urandom, $urandom, $urandom);
                else
                    query(pick_query(n));
            end
            drain();
        end

        if (table_model.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/pali_pkg.sv
sv/pali_div_cell.sv
sv/pali_divider.sv
sv/polyline_arc_length_interpolator_top.sv
sim/tb_top.sv
